/* sv/aba_pkg.sv */
// Types and constants shared by the acknowledgement batch accumulator.
// Depends on nothing.
`default_nettype none

package aba_pkg;

  localparam int unsigned IdW    = 64;
  localparam int unsigned PortW  = 16;
  localparam int unsigned DrainW = 6;
  localparam int unsigned EcntW  = 3;

  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_DRAIN = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    KIND_STORED = 2'd0,
    KIND_FLUSH  = 2'd1,
    KIND_DRAIN  = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PortW-1:0] port;
  } entry_t;

  // Strobes from the sequencer to the entry store.
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

`default_nettype wire

/* sv/ack_batch_accumulator_top.sv */
// Top level of the acknowledgement batch accumulator: sequencer plus store.
// Depends on aba_pkg, aba_ctrl and aba_store.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one request: an add of an
//   id and port, or a drain of up to drain_count_i of the newest entries.
//   Output channel (out_valid_o/out_ready_i) gives results one per
//   handshake; last_o marks the final result of a request.
//   An add with room, and a drain that finds nothing, give one result,
//   loaded into the output register at the accepting edge.
//   An add into a full stack gives MAX_PENDING+1 results: the new entry at
//   once, then one stored entry per unstalled cycle from the single read
//   port of the store (registered read, read overlapped with emission).
//   A drain of k entries registers the request, then reads the store, then
//   loads its first result; the rest follow one per unstalled cycle.
//   The next request is taken once the final result of the previous one
//   sits in the output register and that register is free or being emptied.
//   A stall on the output holds the output register and pauses the walk.
//   Reset empties the stack and the output register; entry contents are
//   not cleared and are never read before being written.
`default_nettype none

module ack_batch_accumulator_top #(
  parameter int unsigned MAX_PENDING = 5
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire                        req_type_i,
  input  wire  [aba_pkg::IdW-1:0]    client_id_i,
  input  wire  [aba_pkg::PortW-1:0]  server_port_i,
  input  wire  [aba_pkg::DrainW-1:0] drain_count_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic [1:0]                 result_kind_o,
  output logic [aba_pkg::IdW-1:0]    out_client_id_o,
  output logic [aba_pkg::PortW-1:0]  out_server_port_o,
  output logic [aba_pkg::EcntW-1:0]  entry_count_o,
  output logic                       last_o
);
  import aba_pkg::*;

  localparam int unsigned IdxW = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;

  mem_ctl_t        mem_ctl;
  logic [IdxW-1:0] waddr, raddr;
  entry_t          wdata, rdata;

  aba_ctrl #(
    .MAX_PENDING(MAX_PENDING)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .client_id_i      (client_id_i),
    .server_port_i    (server_port_i),
    .drain_count_i    (drain_count_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_o    (result_kind_o),
    .out_client_id_o  (out_client_id_o),
    .out_server_port_o(out_server_port_o),
    .entry_count_o    (entry_count_o),
    .last_o           (last_o),
    .mem_ctl_o        (mem_ctl),
    .waddr_o          (waddr),
    .wdata_o          (wdata),
    .raddr_o          (raddr),
    .rdata_i          (rdata)
  );

  aba_store #(
    .MAX_PENDING(MAX_PENDING)
  ) u_store (
    .clk_i  (clk_i),
    .ctl_i  (mem_ctl),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule

`default_nettype wire

/* sv/aba_store.sv */
// Entry store: one write port, one read port, registered read data.
// Depends on aba_pkg.
`default_nettype none

module aba_store #(
  parameter int unsigned MAX_PENDING = 5
) (
  input  wire                      clk_i,
  input  wire aba_pkg::mem_ctl_t   ctl_i,
  input  wire  [((MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1)-1:0] waddr_i,
  input  wire aba_pkg::entry_t     wdata_i,
  input  wire  [((MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1)-1:0] raddr_i,
  output aba_pkg::entry_t          rdata_o
);
  import aba_pkg::*;

  entry_t mem_q [MAX_PENDING];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/aba_ctrl.sv */
// Sequencer: takes requests, keeps the stored count, walks the store for
// flushes and drains, and holds the output register. Depends on aba_pkg.
`default_nettype none

module aba_ctrl #(
  parameter int unsigned MAX_PENDING = 5
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire                          req_type_i,
  input  wire  [aba_pkg::IdW-1:0]      client_id_i,
  input  wire  [aba_pkg::PortW-1:0]    server_port_i,
  input  wire  [aba_pkg::DrainW-1:0]   drain_count_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [1:0]                   result_kind_o,
  output logic [aba_pkg::IdW-1:0]      out_client_id_o,
  output logic [aba_pkg::PortW-1:0]    out_server_port_o,
  output logic [aba_pkg::EcntW-1:0]    entry_count_o,
  output logic                         last_o,
  output aba_pkg::mem_ctl_t            mem_ctl_o,
  output logic [((MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1)-1:0] waddr_o,
  output aba_pkg::entry_t              wdata_o,
  output logic [((MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1)-1:0] raddr_o,
  input  wire aba_pkg::entry_t         rdata_i
);
  import aba_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_PENDING + 1);
  localparam int unsigned IdxW = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   ptr_q, ptr_d;
  logic [CntW-1:0]   rem_q, rem_d;
  logic              rd_pend_q, rd_pend_d;
  logic              rd_last_q, rd_last_d;
  kind_e             kind_q, kind_d;
  logic [EcntW-1:0]  ecnt_q, ecnt_d;
  logic              out_valid_q, out_valid_d;
  kind_e             out_kind_q, out_kind_d;
  logic [IdW-1:0]    out_id_q, out_id_d;
  logic [PortW-1:0]  out_port_q, out_port_d;
  logic [EcntW-1:0]  out_ecnt_q, out_ecnt_d;
  logic              out_last_q, out_last_d;

  logic              out_free, accept, consume, issue, is_add, full;
  logic [CntW-1:0]   want_clip;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && !rd_pend_q && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign consume    = rd_pend_q && out_free;
  assign issue      = (state_q == ST_EMIT) && (rem_q != '0) && (!rd_pend_q || consume);
  assign is_add     = (req_e'(req_type_i) == REQ_ADD);
  assign full       = (cnt_q == CntW'(MAX_PENDING));
  assign want_clip  = (drain_count_i > DrainW'(cnt_q)) ? cnt_q : CntW'(drain_count_i);

  assign mem_ctl_o.we = accept && is_add && !full;
  assign mem_ctl_o.re = issue;
  assign waddr_o      = cnt_q[IdxW-1:0];
  assign wdata_o.id   = client_id_i;
  assign wdata_o.port = server_port_i;
  assign raddr_o      = ptr_q[IdxW-1:0];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    rem_d       = rem_q;
    kind_d      = kind_q;
    ecnt_d      = ecnt_q;
    rd_last_d   = rd_last_q;
    rd_pend_d   = issue || (rd_pend_q && !consume);
    out_valid_d = out_valid_q && !out_ready_i;
    out_kind_d  = out_kind_q;
    out_id_d    = out_id_q;
    out_port_d  = out_port_q;
    out_ecnt_d  = out_ecnt_q;
    out_last_d  = out_last_q;

    if (issue) begin
      ptr_d     = ptr_q + CntW'(1);
      rem_d     = rem_q - CntW'(1);
      rd_last_d = (rem_q == CntW'(1));
    end

    if (consume) begin
      out_valid_d = 1'b1;
      out_kind_d  = kind_q;
      out_id_d    = rdata_i.id;
      out_port_d  = rdata_i.port;
      out_ecnt_d  = ecnt_q;
      out_last_d  = rd_last_q;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_add && !full) begin
            cnt_d       = cnt_q + CntW'(1);
            out_valid_d = 1'b1;
            out_kind_d  = KIND_STORED;
            out_id_d    = '0;
            out_port_d  = '0;
            out_ecnt_d  = EcntW'(cnt_q + CntW'(1));
            out_last_d  = 1'b1;
          end else if (is_add) begin
            // new entry leads the batch, then the stack bottom to top
            cnt_d       = '0;
            ptr_d       = '0;
            rem_d       = cnt_q;
            kind_d      = KIND_FLUSH;
            ecnt_d      = EcntW'(cnt_q + CntW'(1));
            out_valid_d = 1'b1;
            out_kind_d  = KIND_FLUSH;
            out_id_d    = client_id_i;
            out_port_d  = server_port_i;
            out_ecnt_d  = EcntW'(cnt_q + CntW'(1));
            out_last_d  = (cnt_q == '0);
            state_d     = (cnt_q == '0) ? ST_IDLE : ST_EMIT;
          end else if (want_clip == '0) begin
            out_valid_d = 1'b1;
            out_kind_d  = KIND_EMPTY;
            out_id_d    = '0;
            out_port_d  = '0;
            out_ecnt_d  = '0;
            out_last_d  = 1'b1;
          end else begin
            cnt_d   = cnt_q - want_clip;
            ptr_d   = cnt_q - want_clip;
            rem_d   = want_clip;
            kind_d  = KIND_DRAIN;
            ecnt_d  = EcntW'(want_clip);
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if ((rem_d == '0) && !rd_pend_d) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ptr_q       <= '0;
      rem_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      rem_q       <= rem_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    ecnt_q     <= ecnt_d;
    rd_last_q  <= rd_last_d;
    out_kind_q <= out_kind_d;
    out_id_q   <= out_id_d;
    out_port_q <= out_port_d;
    out_ecnt_q <= out_ecnt_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = out_kind_q;
  assign out_client_id_o   = out_id_q;
  assign out_server_port_o = out_port_q;
  assign entry_count_o     = out_ecnt_q;
  assign last_o            = out_last_q;

endmodule

`default_nettype wire

/* sv/aba_checker.sv */
// Port-level checks for the accumulator top, bound in below.
// Depends on aba_pkg and ack_batch_accumulator_top.
`default_nettype none

module aba_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        in_valid_i,
  input wire                        in_ready_o,
  input wire                        req_type_i,
  input wire                        out_valid_o,
  input wire                        out_ready_i,
  input wire  [1:0]                 result_kind_o,
  input wire  [aba_pkg::IdW-1:0]    out_client_id_o,
  input wire  [aba_pkg::PortW-1:0]  out_server_port_o,
  input wire  [aba_pkg::EcntW-1:0]  entry_count_o,
  input wire                        last_o
);
  import aba_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_client_id_o)
      && $stable(out_server_port_o) && $stable(entry_count_o)
      && $stable(result_kind_o) && $stable(last_o))
    else $error("result changed while stalled");

  a_ready_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o || out_ready_i)
    else $error("request taken with output slot occupied");

  a_single_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KIND_STORED || result_kind_o == KIND_EMPTY)
      |-> last_o && out_client_id_o == '0 && out_server_port_o == '0)
    else $error("malformed single result");

  a_add_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && req_type_i == REQ_ADD |=> out_valid_o)
    else $error("add request gave no immediate result");

endmodule

bind ack_batch_accumulator_top aba_checker u_aba_checker (.*);

`default_nettype wire

/* bench/ack_batch_accumulator_top_test.sv */
// Testbench for ack_batch_accumulator_top: directed and random add and drain requests,
// with every result checked against a bench-side model of the acknowledgement stack.
// Depends on aba_pkg and the accumulator RTL.
module ack_batch_accumulator_top_test;
  import aba_pkg::*;

  localparam int unsigned MaxPending     = 5;
  localparam int unsigned CycleLimit     = 400000;
  localparam int unsigned SettleCycles   = MaxPending + 12;
  localparam int unsigned RandomRequests = 385;
  localparam int unsigned MaxPrinted     = 100;

  typedef struct {
    kind_e             kind;
    logic [IdW-1:0]    id;
    logic [PortW-1:0]  port;
    logic [EcntW-1:0]  count;
    logic              last;
  } ack_result_t;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  wire                in_ready;
  req_e               req_type    = REQ_ADD;
  logic [IdW-1:0]     client_id   = '0;
  logic [PortW-1:0]   server_port = '0;
  logic [DrainW-1:0]  drain_count = '0;
  wire                out_valid;
  logic               out_ready   = 1'b0;
  wire  [1:0]         result_kind;
  wire  [IdW-1:0]     out_client_id;
  wire  [PortW-1:0]   out_server_port;
  wire  [EcntW-1:0]   entry_count;
  wire                last;

  // Model of the pending stack
  logic [IdW-1:0]     stack_ids   [MaxPending];
  logic [PortW-1:0]   stack_ports [MaxPending];
  int unsigned        stack_depth = 0;
  ack_result_t        awaited_results[$];

  int unsigned        mismatches  = 0;
  int unsigned        cycle_count = 0;
  bit                 tx_steady   = 1'b0;
  bit                 rx_steady   = 1'b0;

  ack_batch_accumulator_top #(
    .MAX_PENDING(MaxPending)
  ) dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .req_type_i        (req_type),
    .client_id_i       (client_id),
    .server_port_i     (server_port),
    .drain_count_i     (drain_count),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .result_kind_o     (result_kind),
    .out_client_id_o   (out_client_id),
    .out_server_port_o (out_server_port),
    .entry_count_o     (entry_count),
    .last_o            (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    if (mismatches < MaxPrinted) $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  function automatic void queue_result(kind_e kind, logic [IdW-1:0] id,
                                       logic [PortW-1:0] port, int unsigned count,
                                       bit is_last);
    ack_result_t r;
    r.kind  = kind;
    r.id    = id;
    r.port  = port;
    r.count = EcntW'(count);
    r.last  = is_last;
    awaited_results.push_back(r);
  endfunction

  function automatic void accumulate_request(req_e req, logic [IdW-1:0] id,
                                             logic [PortW-1:0] port,
                                             logic [DrainW-1:0] want_raw);
    int unsigned want;
    int unsigned i;
    if (req == REQ_ADD) begin
      if (stack_depth < MaxPending) begin
        stack_ids[stack_depth]   = id;
        stack_ports[stack_depth] = port;
        stack_depth++;
        queue_result(KIND_STORED, '0, '0, stack_depth, 1'b1);
      end else begin
        // full: new acknowledgement leads, then the stack bottom to top
        queue_result(KIND_FLUSH, id, port, stack_depth + 1, stack_depth == 0);
        for (i = 0; i < stack_depth; i++)
          queue_result(KIND_FLUSH, stack_ids[i], stack_ports[i], stack_depth + 1,
                       i + 1 == stack_depth);
        stack_depth = 0;
      end
    end else begin
      want = want_raw;
      if (want > stack_depth) want = stack_depth;
      if (want == 0) begin
        queue_result(KIND_EMPTY, '0, '0, 0, 1'b1);
      end else begin
        for (i = stack_depth - want; i < stack_depth; i++)
          queue_result(KIND_DRAIN, stack_ids[i], stack_ports[i], want,
                       i + 1 == stack_depth);
        stack_depth -= want;
      end
    end
  endfunction

  function automatic logic [IdW-1:0] rand_id();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [PortW-1:0] rand_port();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PortW'($urandom);
    endcase
  endfunction

  // Valid is left high after acceptance; the next call either keeps it up or drops it.
  task automatic send_request(req_e req, logic [IdW-1:0] id, logic [PortW-1:0] port,
                              logic [DrainW-1:0] want);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    client_id   <= id;
    server_port <= port;
    drain_count <= want;
    do @(posedge clk); while (!(in_valid && in_ready));
    accumulate_request(req, id, port, want);
  endtask

  task automatic await_quiet();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    ack_result_t exp;
    int unsigned gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d id=%h port=%h count=%0d last=%b",
                                  result_kind, out_client_id, out_server_port,
                                  entry_count, last));
      end else begin
        exp = awaited_results.pop_front();
        if (result_kind !== exp.kind || out_client_id !== exp.id ||
            out_server_port !== exp.port || entry_count !== exp.count ||
            last !== exp.last)
          report_mismatch($sformatf(
            "kind %0d/%0d id %h/%h port %h/%h count %0d/%0d last %b/%b (got/exp)",
            result_kind, exp.kind, out_client_id, exp.id, out_server_port, exp.port,
            entry_count, exp.count, last, exp.last));
      end
    end
  end

  task automatic test_empty_drain();
    send_request(REQ_DRAIN, rand_id(), rand_port(), 6'd0);
    send_request(REQ_DRAIN, rand_id(), rand_port(), 6'd63);
  endtask

  task automatic test_fill_and_flush();
    send_request(REQ_ADD, '0, '0, 6'd0);
    send_request(REQ_ADD, '1, '1, 6'd63);
    send_request(REQ_ADD, {32{2'b10}}, 16'hAAAA, 6'd21);
    send_request(REQ_ADD, {32{2'b01}}, 16'h5555, 6'd42);
    send_request(REQ_ADD, 64'd1, 16'd1, 6'd0);
    send_request(REQ_ADD, 64'h8000_0000_0000_0000, 16'h8000, 6'd5);
    send_request(REQ_ADD, '1, 16'h1234, 6'd1);
  endtask

  task automatic test_drain_clipping();
    int unsigned i;
    send_request(REQ_ADD, rand_id(), rand_port(), 6'd0);
    send_request(REQ_ADD, rand_id(), rand_port(), 6'd0);
    send_request(REQ_DRAIN, rand_id(), rand_port(), 6'd0);
    send_request(REQ_DRAIN, rand_id(), rand_port(), 6'd2);
    send_request(REQ_ADD, rand_id(), rand_port(), 6'd0);
    send_request(REQ_DRAIN, rand_id(), rand_port(), 6'd63);
    for (i = 0; i < 3; i++) send_request(REQ_ADD, rand_id(), rand_port(), 6'd0);
    send_request(REQ_DRAIN, rand_id(), rand_port(), 6'd32);
    for (i = 0; i < MaxPending; i++) send_request(REQ_ADD, rand_id(), rand_port(), 6'd0);
    send_request(REQ_DRAIN, rand_id(), rand_port(), 6'(MaxPending));
  endtask

  task automatic test_pause_until_empty();
    int unsigned i;
    for (i = 0; i < 3; i++) send_request(REQ_ADD, rand_id(), rand_port(), 6'd0);
    await_quiet();
    send_request(REQ_DRAIN, rand_id(), rand_port(), 6'd4);
  endtask

  task automatic test_random_traffic();
    int unsigned i;
    logic [DrainW-1:0] want;
    for (i = 0; i < RandomRequests; i++) begin
      if (i % 48 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      if (i >= 200 && i < 240) begin
        tx_steady = 1'b1;
        rx_steady = 1'b1;
      end
      if ($urandom_range(0, 99) < 55) begin
        send_request(REQ_ADD, rand_id(), rand_port(), DrainW'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0:       want = '0;
          1:       want = DrainW'($urandom_range(0, 63));
          default: want = DrainW'($urandom_range(1, stack_depth + 1));
        endcase
        send_request(REQ_DRAIN, rand_id(), rand_port(), want);
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_drain();
    test_fill_and_flush();
    test_drain_clipping();
    test_pause_until_empty();
    test_random_traffic();
    await_quiet();
    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* ack_batch_accumulator_top.f */
sv/aba_pkg.sv
sv/aba_store.sv
sv/aba_ctrl.sv
sv/ack_batch_accumulator_top.sv
sv/aba_checker.sv
bench/ack_batch_accumulator_top_test.sv
